FILE: hdl/rbs_pkg.sv
package rbs_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int NUM_AXES     = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 2;
    localparam int TMAG_W       = 63;

    // largest |t| in the 64-bit slab parameter format
    localparam logic [TMAG_W-1:0] T_MAG_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
    } t_ray_in;

    typedef struct packed {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] hit_x;
        logic signed [COORD_WIDTH-1:0] hit_y;
        logic signed [COORD_WIDTH-1:0] hit_z;
    } t_ray_out;

    // one axis after classification: magnitudes of (bound - origin) and |dir|
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin;
        logic [COORD_WIDTH-1:0]        den;
        logic                          dir_neg;
        logic [COORD_WIDTH-1:0]        lo_mag;
        logic                          lo_neg;
        logic [COORD_WIDTH-1:0]        hi_mag;
        logic                          hi_neg;
        logic                          par;
        logic                          outside;
    } t_axis;

    typedef struct packed {
        t_axis [NUM_AXES-1:0] ax;
    } t_slab_word;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: hdl/rbs_front.sv
module rbs_front #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rbs_pkg::COORD_WIDTH-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  rbs_pkg::t_ray_in                    i_ray,
    output logic                                o_push,
    output rbs_pkg::t_slab_word                 o_word
);

    localparam int CW = rbs_pkg::COORD_WIDTH;
    localparam int NA = rbs_pkg::NUM_AXES;
    // |dir| at or below this counts as parallel
    localparam logic [CW-1:0] PAR_THR = CW'((64'd15 << FRAC_BITS) / 64'd100000000);

    logic signed [CW-1:0] r_lo [NA];
    logic signed [CW-1:0] r_hi [NA];
    logic                 r_vld;
    rbs_pkg::t_slab_word  r_word;
    rbs_pkg::t_slab_word  n_word;

    logic signed [CW-1:0] org [NA];
    logic signed [CW-1:0] dir [NA];

    assign org[0] = i_ray.origin_x;
    assign org[1] = i_ray.origin_y;
    assign org[2] = i_ray.origin_z;
    assign dir[0] = i_ray.dir_x;
    assign dir[1] = i_ray.dir_y;
    assign dir[2] = i_ray.dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NA; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbs_pkg::CFG_MIN_X: r_lo[0] <= i_cfg_data;
                rbs_pkg::CFG_MIN_Y: r_lo[1] <= i_cfg_data;
                rbs_pkg::CFG_MIN_Z: r_lo[2] <= i_cfg_data;
                rbs_pkg::CFG_MAX_X: r_hi[0] <= i_cfg_data;
                rbs_pkg::CFG_MAX_Y: r_hi[1] <= i_cfg_data;
                rbs_pkg::CFG_MAX_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [CW:0] lo_d;
        logic signed [CW:0] hi_d;
        logic signed [CW:0] lo_n;
        logic signed [CW:0] hi_n;
        logic signed [CW:0] d_e;
        logic signed [CW:0] d_n;
        n_word = '0;
        for (int a = 0; a < NA; a++) begin
            lo_d = $signed({r_lo[a][CW-1], r_lo[a]}) - $signed({org[a][CW-1], org[a]});
            hi_d = $signed({r_hi[a][CW-1], r_hi[a]}) - $signed({org[a][CW-1], org[a]});
            lo_n = -lo_d;
            hi_n = -hi_d;
            d_e  = $signed({dir[a][CW-1], dir[a]});
            d_n  = -d_e;
            n_word.ax[a].origin  = org[a];
            n_word.ax[a].dir_neg = dir[a][CW-1];
            n_word.ax[a].den     = dir[a][CW-1] ? d_n[CW-1:0] : d_e[CW-1:0];
            n_word.ax[a].lo_neg  = lo_d[CW];
            n_word.ax[a].lo_mag  = lo_d[CW] ? lo_n[CW-1:0] : lo_d[CW-1:0];
            n_word.ax[a].hi_neg  = hi_d[CW];
            n_word.ax[a].hi_mag  = hi_d[CW] ? hi_n[CW-1:0] : hi_d[CW-1:0];
            n_word.ax[a].par     = n_word.ax[a].den <= PAR_THR;
            n_word.ax[a].outside = (org[a] < r_lo[a]) || (org[a] > r_hi[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_word <= n_word;
        end
    end

    assign o_push = r_vld;
    assign o_word = r_word;

endmodule

FILE: hdl/rbs_queue.sv
module rbs_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rbs_pkg::t_slab_word  i_word,
    input  logic                 i_pop,
    output rbs_pkg::t_slab_word  o_word,
    output rbs_pkg::t_q_status   o_status
);

    localparam int D  = rbs_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CNW = $clog2(D + 1);

    rbs_pkg::t_slab_word r_mem [D];
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [CNW-1:0]      r_cnt;
    logic                full;
    logic                empty;
    logic                do_push;
    logic                do_pop;

    assign full    = r_cnt == CNW'(D);
    assign empty   = r_cnt == '0;
    assign do_pop  = i_pop && !empty;
    assign do_push = i_push && (!full || do_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(D - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(D - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CNW'(do_push) - CNW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    assign o_word = r_mem[r_rp];
    assign o_status.push  = i_push;
    assign o_status.pop   = i_pop;
    assign o_status.full  = full;
    assign o_status.empty = empty;

endmodule

FILE: hdl/rbs_div.sv
module rbs_div #(
    parameter int NUM_W = rbs_pkg::COORD_WIDTH + rbs_pkg::FRAC_BITS,
    parameter int DEN_W = rbs_pkg::COORD_WIDTH
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    // restoring divide, one quotient bit per stage
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_num [NUM_W];
    logic [NUM_W-1:0] n_quo [NUM_W];

    always_comb begin
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) begin
                rem_in = '0;
                num_in = i_num;
                quo_in = '0;
                den_in = i_den;
            end else begin
                rem_in = r_rem[k-1];
                num_in = r_num[k-1];
                quo_in = r_quo[k-1];
                den_in = r_den[k-1];
            end
            trial    = {rem_in, num_in[NUM_W-1]};
            ge       = trial >= {1'b0, den_in};
            n_rem[k] = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
            n_num[k] = num_in << 1;
            n_quo[k] = {quo_in[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_W; k++) begin
            r_rem[k] <= n_rem[k];
            r_num[k] <= n_num[k];
            r_quo[k] <= n_quo[k];
            r_den[k] <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1];
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule

FILE: hdl/rbs_back.sv
module rbs_back #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  rbs_pkg::t_slab_word  i_word,
    output logic                 o_valid,
    output rbs_pkg::t_ray_out    o_result
);

    localparam int CW = rbs_pkg::COORD_WIDTH;
    localparam int NA = rbs_pkg::NUM_AXES;
    localparam int TM = rbs_pkg::TMAG_W;
    localparam int NW = CW + FRAC_BITS;
    localparam int QX = (NW > TM) ? NW : TM;
    localparam int PW = CW + TM;
    localparam int SW = PW - FRAC_BITS + 1;
    localparam logic signed [63:0] T_POS = $signed({1'b0, rbs_pkg::T_MAG_MAX});
    localparam logic signed [63:0] T_NEG = -T_POS;
    localparam logic signed [64:0] SUM_HI = (65'sd1 <<< (CW - 1)) - 65'sd1;
    localparam logic signed [64:0] SUM_LO = -SUM_HI - 65'sd1;
    localparam logic signed [CW-1:0] LIM_HI = SUM_HI[CW-1:0];
    localparam logic signed [CW-1:0] LIM_LO = SUM_LO[CW-1:0];

    function automatic logic signed [63:0] to_t(input logic [NW-1:0] q, input logic neg);
        logic [QX-1:0] qe;
        logic [TM-1:0] m;
        qe = QX'(q);
        m  = (qe > QX'(rbs_pkg::T_MAG_MAX)) ? rbs_pkg::T_MAG_MAX : qe[TM-1:0];
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    // divider lanes: lo-bound and hi-bound parameter per axis
    logic [NW-1:0] quo_lo [NA];
    logic [NW-1:0] quo_hi [NA];

    for (genvar a = 0; a < NA; a++) begin : g_div
        rbs_div #(.NUM_W(NW), .DEN_W(CW)) u_div_lo (
            .i_clk (i_clk),
            .i_num ({i_word.ax[a].lo_mag, {FRAC_BITS{1'b0}}}),
            .i_den (i_word.ax[a].den),
            .o_quo (quo_lo[a])
        );
        rbs_div #(.NUM_W(NW), .DEN_W(CW)) u_div_hi (
            .i_clk (i_clk),
            .i_num ({i_word.ax[a].hi_mag, {FRAC_BITS{1'b0}}}),
            .i_den (i_word.ax[a].den),
            .o_quo (quo_hi[a])
        );
    end

    // word and valid ride alongside the divider stages
    rbs_pkg::t_slab_word r_dw [NW];
    logic                r_dv [NW];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NW; k++) begin
            r_dw[k] <= (k == 0) ? i_word : r_dw[(k == 0) ? 0 : k-1];
        end
    end

    // S1 ordered t per axis
    logic signed [63:0]  r1_tmin [NA];
    logic signed [63:0]  r1_tmax [NA];
    rbs_pkg::t_slab_word r1_w;
    // S2 narrowed interval
    logic signed [63:0]  r2_near;
    logic signed [63:0]  r2_far;
    logic                r2_out;
    rbs_pkg::t_slab_word r2_w;
    // S3 chosen t
    logic                r3_hit;
    logic                r3_tneg;
    logic [TM-1:0]       r3_tmag;
    rbs_pkg::t_slab_word r3_w;
    // S4 partial products
    logic [CW+31:0]      r4_plo [NA];
    logic [CW+30:0]      r4_phi [NA];
    logic                r4_neg [NA];
    logic                r4_hit;
    rbs_pkg::t_slab_word r4_w;
    // S5 full product
    logic [PW-1:0]       r5_prod [NA];
    logic                r5_neg [NA];
    logic                r5_hit;
    rbs_pkg::t_slab_word r5_w;
    // S6 scaled, rounded toward minus infinity
    logic [SW-1:0]       r6_mag [NA];
    logic                r6_neg [NA];
    logic                r6_hit;
    rbs_pkg::t_slab_word r6_w;
    logic [6:0]          r_sv;
    rbs_pkg::t_ray_out   r_res;
    logic                r_vld;

    logic signed [CW-1:0] pt [NA];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_sv  <= '0;
            r_vld <= 1'b0;
        end else begin
            for (int k = 0; k < NW; k++) begin
                r_dv[k] <= (k == 0) ? i_vld : r_dv[(k == 0) ? 0 : k-1];
            end
            r_sv  <= {r_sv[5:0], r_dv[NW-1]};
            r_vld <= r_sv[5];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [63:0] t0;
        logic signed [63:0] t1;
        for (int a = 0; a < NA; a++) begin
            t0 = to_t(quo_lo[a], r_dw[NW-1].ax[a].lo_neg ^ r_dw[NW-1].ax[a].dir_neg);
            t1 = to_t(quo_hi[a], r_dw[NW-1].ax[a].hi_neg ^ r_dw[NW-1].ax[a].dir_neg);
            r1_tmin[a] <= (t0 > t1) ? t1 : t0;
            r1_tmax[a] <= (t0 > t1) ? t0 : t1;
        end
        r1_w <= r_dw[NW-1];
    end

    always_ff @(posedge i_clk) begin
        logic signed [63:0] nr;
        logic signed [63:0] fr;
        logic               ot;
        nr = T_NEG;
        fr = T_POS;
        ot = 1'b0;
        for (int a = 0; a < NA; a++) begin
            if (r1_w.ax[a].par) begin
                ot = ot | r1_w.ax[a].outside;
            end else begin
                if (r1_tmin[a] > nr) nr = r1_tmin[a];
                if (r1_tmax[a] < fr) fr = r1_tmax[a];
            end
        end
        r2_near <= nr;
        r2_far  <= fr;
        r2_out  <= ot;
        r2_w    <= r1_w;
    end

    always_ff @(posedge i_clk) begin
        logic signed [63:0] t;
        logic signed [63:0] tn;
        t  = (r2_near > 64'sd0) ? r2_near : r2_far;
        tn = -t;
        r3_hit  <= !r2_out && !(r2_near > r2_far) && !(r2_far < 64'sd0);
        r3_tneg <= t[63];
        r3_tmag <= t[63] ? tn[TM-1:0] : t[TM-1:0];
        r3_w    <= r2_w;
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NA; a++) begin
            r4_plo[a] <= (CW+32)'(r3_w.ax[a].den) * (CW+32)'(r3_tmag[31:0]);
            r4_phi[a] <= (CW+31)'(r3_w.ax[a].den) * (CW+31)'(r3_tmag[TM-1:32]);
            r4_neg[a] <= r3_w.ax[a].dir_neg ^ r3_tneg;
        end
        r4_hit <= r3_hit;
        r4_w   <= r3_w;
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NA; a++) begin
            r5_prod[a] <= PW'(r4_plo[a]) + (PW'(r4_phi[a]) << 32);
            r5_neg[a]  <= r4_neg[a];
        end
        r5_hit <= r4_hit;
        r5_w   <= r4_w;
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NA; a++) begin
            r6_mag[a] <= SW'(r5_prod[a] >> FRAC_BITS)
                       + SW'(r5_neg[a] && (|r5_prod[a][FRAC_BITS-1:0]));
            r6_neg[a] <= r5_neg[a];
        end
        r6_hit <= r5_hit;
        r6_w   <= r5_w;
    end

    always_comb begin
        logic signed [64:0] v;
        logic signed [64:0] s;
        logic signed [64:0] mg;
        for (int a = 0; a < NA; a++) begin
            mg = $signed({3'b000, r6_mag[a][61:0]});
            v  = r6_neg[a] ? -mg : mg;
            s  = $signed({{(65-CW){r6_w.ax[a].origin[CW-1]}}, r6_w.ax[a].origin}) + v;
            if (|r6_mag[a][SW-1:62]) begin
                pt[a] = r6_neg[a] ? LIM_LO : LIM_HI;
            end else if (s > SUM_HI) begin
                pt[a] = LIM_HI;
            end else if (s < SUM_LO) begin
                pt[a] = LIM_LO;
            end else begin
                pt[a] = s[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.hit   <= r6_hit;
        r_res.hit_x <= r6_hit ? pt[0] : '0;
        r_res.hit_y <= r6_hit ? pt[1] : '0;
        r_res.hit_z <= r6_hit ? pt[2] : '0;
    end

    assign o_valid  = r_vld;
    assign o_result = r_res;

endmodule

FILE: hdl/ray_box_slab_intersect.sv
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+--------------------------
// ray in   | start, busy, i_ray                      | taken when start & !busy
// result   | o_valid, o_result                       | one-cycle strobe, no stall
// config   | i_cfg_we, i_cfg_idx, i_cfg_data         | write on i_cfg_we
//
// One ray per cycle, sustained. Latency is set by the bit-per-stage slab dividers
// (six lanes) plus front, queue, narrowing and the split hit-point multiply. busy
// is high in reset and for the first cycle after it; reset is synchronous and
// clears the box to zero and empties the pipeline.
module ray_box_slab_intersect #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  rbs_pkg::t_ray_in                i_ray,
    input  logic                            i_cfg_we,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rbs_pkg::COORD_WIDTH-1:0] i_cfg_data,
    output logic                            o_valid,
    output rbs_pkg::t_ray_out               o_result
);

    localparam int LAT = rbs_pkg::COORD_WIDTH + FRAC_BITS + 9;

    logic                r_busy;
    logic                accept;
    logic                push;
    rbs_pkg::t_slab_word f_word;
    rbs_pkg::t_slab_word q_word;
    rbs_pkg::t_q_status  q_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy | ~i_rst_n;
    assign accept = start & ~busy;

    rbs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_ray      (i_ray),
        .o_push     (push),
        .o_word     (f_word)
    );

    // back side never stalls: drain whenever a word is waiting
    rbs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (f_word),
        .i_pop    (!q_st.empty),
        .o_word   (q_word),
        .o_status (q_st)
    );

    rbs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (!q_st.empty),
        .i_word   (q_word),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_st.push && q_st.full |-> q_st.pop)
        else $error("queue overflow");

    a_q_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_st.pop |-> !q_st.empty)
        else $error("queue pop while empty");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_valid)
        else $error("result missing after accepted ray");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.hit |-> o_result.hit_x == '0 && o_result.hit_y == '0
            && o_result.hit_z == '0)
        else $error("miss with nonzero point");

endmodule
